FILE: hw/rtl/pcfm_pkg.sv
// Package for the pack cell fault monitor: item structs, codes, sizes.
// Used by pcfm_ctrl, pcfm_dp and pack_cell_fault_monitor_unit; no dependencies.
package pcfm_pkg;

	// Pack geometry
	localparam int MODULES          = 16;
	localparam int CELLS_PER_MODULE = 12;
	localparam int MOD_IDX_W        = (MODULES > 1) ? $clog2(MODULES) : 1;
	localparam int CELL_CNT_W       = $clog2(CELLS_PER_MODULE + 1);

	// Field widths
	localparam int MV_W     = 13;
	localparam int TEMP_W   = 12;
	localparam int AGE_W    = 16;
	localparam int ADDR_W   = 5;
	localparam int MODSUM_W = 16;
	localparam int PACK_W   = 20;
	localparam int PRES_W   = 5;
	localparam int PAR_W    = 4;
	localparam int DIVCNT_W = $clog2(PACK_W);

	localparam logic [MV_W-1:0]     IGNORE_CELL_MV = MV_W'(100);
	localparam logic [ADDR_W-1:0]   MODULES_ADDR   = ADDR_W'(MODULES);
	localparam logic [MODSUM_W-1:0] MODSUM_MAX     = '1;
	localparam logic [PACK_W-1:0]   PACK_MAX       = '1;
	localparam logic [PRES_W-1:0]   PRES_MAX       = '1;
	localparam logic [DIVCNT_W-1:0] DIV_LAST       = DIVCNT_W'(PACK_W - 1);

	// Flag bit positions (faults: OV/UV, alerts: OT/UT)
	localparam int FLAG_LOW  = 0;
	localparam int FLAG_HIGH = 1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OVER_VOLTAGE  = 3'd0,
		CFG_UNDER_VOLTAGE = 3'd1,
		CFG_OVER_TEMP     = 3'd2,
		CFG_UNDER_TEMP    = 3'd3,
		CFG_PARALLEL      = 3'd4,
		CFG_TIMEOUT       = 3'd5
	} cfg_idx_t;
	localparam int CFG_DATA_W = 16;

	// Input item kinds
	typedef enum logic [1:0] {
		KIND_CELL  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ROUND = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	localparam logic REPORT_MODULE = 1'b0;
	localparam logic REPORT_PACK   = 1'b1;

	typedef struct packed {
		logic [1:0]               kind;
		logic [ADDR_W-1:0]        module_addr;
		logic [MV_W-1:0]          cell_mv;
		logic signed [TEMP_W-1:0] temp_a;
		logic signed [TEMP_W-1:0] temp_b;
		logic [AGE_W-1:0]         data_age_ms;
	} in_item_t;

	typedef struct packed {
		logic                report_kind;
		logic [ADDR_W-1:0]   report_module;
		logic                module_alive;
		logic [MODSUM_W-1:0] module_mv;
		logic                over_voltage_fault;
		logic                under_voltage_fault;
		logic                over_temp_alert;
		logic                under_temp_alert;
		logic [PACK_W-1:0]   pack_mv;
		logic [PRES_W-1:0]   present_count;
		logic                pack_faulted;
	} out_item_t;

	// Controller -> datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic div_step;
		logic emit;
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic is_close;
		logic is_round;
		logic addr_ok;
		logic div_needed;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

FILE: hw/rtl/pcfm_ctrl.sv
// Controller state machine for the pack cell fault monitor.
// Depends on pcfm_pkg; drives pcfm_dp through cmd_t and reads status_t.
module pcfm_ctrl import pcfm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_DIV  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (status.is_close && status.addr_ok) begin
					state_d = S_EMIT;
				end else if (status.is_round) begin
					state_d = status.div_needed ? S_DIV : S_EMIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result emitted while output register full");

	a_plain_exec_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && !status.is_close && !status.is_round) |=> state_q == S_IDLE)
		else $error("resultless item did not return to idle");

	a_div_only_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && state_d == S_DIV) |-> (status.is_round && status.div_needed))
		else $error("divider started for a non-round item");
`endif

endmodule

FILE: hw/rtl/pcfm_dp.sv
// Datapath for the pack cell fault monitor: config registers, cell and pack
// accumulators, per-module flags, bit-serial divider and output register.
// Depends on pcfm_pkg; sequenced by pcfm_ctrl.
module pcfm_dp import pcfm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  in_item_t              in_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	// Configuration
	logic [MV_W-1:0]          over_voltage_q, under_voltage_q;
	logic signed [TEMP_W-1:0] over_temp_q, under_temp_q;
	logic [PAR_W-1:0]         parallel_q;
	logic [AGE_W-1:0]         timeout_q;

	// Working state
	in_item_t              item_q;
	logic [MODSUM_W-1:0]   cell_sum_q;
	logic [1:0]            cell_fault_q;
	logic [CELL_CNT_W-1:0] cell_count_q;
	logic [PACK_W-1:0]     pack_sum_q;
	logic [PRES_W-1:0]     round_present_q;
	logic [MODULES-1:0]    flagged_q;
	out_item_t             res_q;
	logic [PACK_W-1:0]     div_q;
	logic [PAR_W-1:0]      rem_q;
	logic [DIVCNT_W-1:0]   div_cnt_q;
	logic                  out_valid_q;
	out_item_t             out_data_q;

	// Combinational terms
	logic                  addr_ok;
	logic [MOD_IDX_W-1:0]  mod_idx;
	logic [MODSUM_W:0]     cell_add;
	logic [MODSUM_W-1:0]   cell_sum_sat;
	logic                  cell_counts;
	logic [1:0]            cell_flags;
	logic                  alive;
	logic [1:0]            alert;
	logic [PACK_W:0]       pack_add;
	logic [PACK_W-1:0]     pack_sum_sat;
	logic [PAR_W:0]        div_trial;
	logic                  div_ge;
	logic                  out_free;
	out_item_t             res_d;
	out_item_t             emit_d;

	assign cfg_ready = 1'b1;

	// Decode the held item
	assign addr_ok = (item_q.module_addr != '0) && (item_q.module_addr <= MODULES_ADDR);
	assign mod_idx = MOD_IDX_W'(item_q.module_addr - ADDR_W'(1));

	// Cell accumulation with saturation and fault checks
	always_comb begin
		cell_add     = {1'b0, cell_sum_q} + (MODSUM_W+1)'(item_q.cell_mv);
		cell_sum_sat = cell_add[MODSUM_W] ? MODSUM_MAX : cell_add[MODSUM_W-1:0];
		cell_counts  = cell_count_q < CELL_CNT_W'(CELLS_PER_MODULE);
		cell_flags   = '0;
		if (item_q.cell_mv > IGNORE_CELL_MV) begin
			cell_flags[FLAG_LOW]  = item_q.cell_mv > over_voltage_q;
			cell_flags[FLAG_HIGH] = item_q.cell_mv < under_voltage_q;
		end
	end

	// Module close terms
	always_comb begin
		alive            = item_q.data_age_ms < timeout_q;
		alert[FLAG_LOW]  = (item_q.temp_a > over_temp_q) || (item_q.temp_b > over_temp_q);
		alert[FLAG_HIGH] = (item_q.temp_a < under_temp_q) || (item_q.temp_b < under_temp_q);
		pack_add         = {1'b0, pack_sum_q} + (PACK_W+1)'(cell_sum_q);
		pack_sum_sat     = pack_add[PACK_W] ? PACK_MAX : pack_add[PACK_W-1:0];
	end

	// Assemble the report for the held item
	always_comb begin
		res_d = '0;
		if (item_q.kind == KIND_CLOSE) begin
			res_d.report_kind   = REPORT_MODULE;
			res_d.report_module = item_q.module_addr;
			if (alive) begin
				res_d.module_alive        = 1'b1;
				res_d.module_mv           = cell_sum_q;
				res_d.over_voltage_fault  = cell_fault_q[FLAG_LOW];
				res_d.under_voltage_fault = cell_fault_q[FLAG_HIGH];
				res_d.over_temp_alert     = alert[FLAG_LOW];
				res_d.under_temp_alert    = alert[FLAG_HIGH];
			end
		end else begin
			res_d.report_kind   = REPORT_PACK;
			res_d.present_count = round_present_q;
			res_d.pack_faulted  = |flagged_q;
		end
	end

	// Merge the quotient into a pack report
	always_comb begin
		emit_d = res_q;
		if (res_q.report_kind == REPORT_PACK) begin
			emit_d.pack_mv = div_q;
		end
	end

	// One restoring divide step: quotient bits shift into div_q
	assign div_trial = {rem_q, div_q[PACK_W-1]};
	assign div_ge    = div_trial >= {1'b0, parallel_q};

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		status            = '0;
		status.is_close   = item_q.kind == KIND_CLOSE;
		status.is_round   = item_q.kind == KIND_ROUND;
		status.addr_ok    = addr_ok;
		status.div_needed = parallel_q > PAR_W'(1);
		status.div_last   = div_cnt_q == DIV_LAST;
		status.out_free   = out_free;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_voltage_q  <= MV_W'(4200);
			under_voltage_q <= MV_W'(3000);
			over_temp_q     <= TEMP_W'(550);
			under_temp_q    <= '0;
			parallel_q      <= PAR_W'(1);
			timeout_q       <= AGE_W'(3000);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OVER_VOLTAGE:  over_voltage_q  <= cfg_data[MV_W-1:0];
				CFG_UNDER_VOLTAGE: under_voltage_q <= cfg_data[MV_W-1:0];
				CFG_OVER_TEMP:     over_temp_q     <= cfg_data[TEMP_W-1:0];
				CFG_UNDER_TEMP:    under_temp_q    <= cfg_data[TEMP_W-1:0];
				CFG_PARALLEL:      parallel_q      <= cfg_data[PAR_W-1:0];
				CFG_TIMEOUT:       timeout_q       <= cfg_data[AGE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
	end

	// Accumulators and per-module flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_sum_q      <= '0;
			cell_fault_q    <= '0;
			cell_count_q    <= '0;
			pack_sum_q      <= '0;
			round_present_q <= '0;
			flagged_q       <= '0;
		end else if (cmd.exec) begin
			case (item_q.kind)
				KIND_CELL: begin
					if (cell_counts) begin
						cell_count_q <= cell_count_q + CELL_CNT_W'(1);
						cell_sum_q   <= cell_sum_sat;
						cell_fault_q <= cell_fault_q | cell_flags;
					end
				end
				KIND_CLOSE: begin
					if (addr_ok) begin
						flagged_q[mod_idx] <= alive && ((cell_fault_q | alert) != '0);
						if (alive) begin
							pack_sum_q <= pack_sum_sat;
							if (round_present_q != PRES_MAX) begin
								round_present_q <= round_present_q + PRES_W'(1);
							end
						end
					end
					cell_sum_q   <= '0;
					cell_fault_q <= '0;
					cell_count_q <= '0;
				end
				KIND_ROUND: begin
					pack_sum_q      <= '0;
					round_present_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Build the pending result; run the divider over the pack sum
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q     <= res_d;
			div_q     <= pack_sum_q;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= div_ge ? PAR_W'(div_trial - {1'b0, parallel_q})
			                    : div_trial[PAR_W-1:0];
			div_q     <= {div_q[PACK_W-2:0], div_ge};
			div_cnt_q <= div_cnt_q + DIVCNT_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= emit_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_cell_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cell_count_q <= CELL_CNT_W'(CELLS_PER_MODULE))
		else $error("cell count beyond cells per module");

	a_pack_report_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.report_kind == REPORT_PACK) |->
		(out_data_q.report_module == '0 && !out_data_q.module_alive))
		else $error("pack report carries module fields");

	a_round_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && item_q.kind == KIND_ROUND) |=> (pack_sum_q == '0 && round_present_q == '0))
		else $error("round end did not clear pack accumulators");
`endif

endmodule

FILE: hw/rtl/pack_cell_fault_monitor_unit.sv
// Each item is loaded in IDLE and handled in EXEC; a close with a valid address or
// a round end then goes to EMIT for a registered result, a round end first running
// the 20-step divider when the parallel count exceeds one. One item at a time.
// The next item is taken while a result still waits in the output register.
// Reset (arst_n low, asynchronous) clears control and sums; restores config defaults.
// Top level of the pack cell fault monitor: joins pcfm_ctrl and pcfm_dp.
module pack_cell_fault_monitor_unit import pcfm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	pcfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	pcfm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: dv/pcfm_checker.sv
// Checker for pack_cell_fault_monitor_unit: watches the item, result and register channels,
// predicts every report and compares each one field by field.
// Depends on pcfm_pkg for the item structs, item kinds and register codes.
`timescale 1ns / 100ps

module pcfm_checker import pcfm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    reports_due,
	output int                    module_reports,
	output int                    pack_reports
);

	// Threshold registers as the block should hold them
	logic [MV_W-1:0]          ov_limit;
	logic [MV_W-1:0]          uv_limit;
	logic signed [TEMP_W-1:0] ot_limit;
	logic signed [TEMP_W-1:0] ut_limit;
	logic [PAR_W-1:0]         strings;
	logic [AGE_W-1:0]         fresh_ms;

	// Per-module stored status
	logic       seen_alive [1:MODULES];
	logic [1:0] volt_flags [1:MODULES];
	logic [1:0] temp_flags [1:MODULES];

	// Running sums of the current module and round
	int unsigned cells_mv;
	int unsigned cells_taken;
	logic [1:0]  cells_flags;
	int unsigned pack_mv_sum;
	int unsigned alive_in_round;

	out_item_t due_reports [$];
	int        errors = 0;
	int        n_mod  = 0;
	int        n_pack = 0;

	function automatic void clear_cells();
		cells_mv    = 0;
		cells_taken = 0;
		cells_flags = '0;
	endfunction

	function automatic void reset_monitor();
		ov_limit = MV_W'(4200);
		uv_limit = MV_W'(3000);
		ot_limit = TEMP_W'(550);
		ut_limit = '0;
		strings  = PAR_W'(1);
		fresh_ms = AGE_W'(3000);
		for (int m = 1; m <= MODULES; m++) begin
			seen_alive[m] = 1'b0;
			volt_flags[m] = '0;
			temp_flags[m] = '0;
		end
		clear_cells();
		pack_mv_sum    = 0;
		alive_in_round = 0;
		due_reports.delete();
	endfunction

	// Advance the monitor by one item; returns 1 when the item yields a report
	function automatic bit next_report(input in_item_t it, output out_item_t rep);
		logic [1:0]  alert;
		logic        alive;
		int unsigned pv;
		bit          faulted;
		rep     = '0;
		alert   = '0;
		faulted = 1'b0;
		case (kind_t'(it.kind))
		KIND_CELL: begin
			// only the first cells of a module count; low readings skip the fault checks
			if (cells_taken < CELLS_PER_MODULE) begin
				cells_taken++;
				cells_mv += it.cell_mv;
				if (cells_mv > MODSUM_MAX)
					cells_mv = MODSUM_MAX;
				if (it.cell_mv > IGNORE_CELL_MV) begin
					if (it.cell_mv > ov_limit)
						cells_flags[FLAG_LOW] = 1'b1;
					if (it.cell_mv < uv_limit)
						cells_flags[FLAG_HIGH] = 1'b1;
				end
			end
			return 1'b0;
		end
		KIND_CLOSE: begin
			// an address outside the pack only drops the pending cells
			if (it.module_addr == '0 || it.module_addr > MODULES_ADDR) begin
				clear_cells();
				return 1'b0;
			end
			alive = it.data_age_ms < fresh_ms;
			seen_alive[it.module_addr] = alive;
			rep.report_kind   = REPORT_MODULE;
			rep.report_module = it.module_addr;
			if (alive) begin
				if (it.temp_a > ot_limit || it.temp_b > ot_limit)
					alert[FLAG_LOW] = 1'b1;
				if (it.temp_a < ut_limit || it.temp_b < ut_limit)
					alert[FLAG_HIGH] = 1'b1;
				volt_flags[it.module_addr] = cells_flags;
				temp_flags[it.module_addr] = alert;
				pack_mv_sum += cells_mv;
				if (pack_mv_sum > PACK_MAX)
					pack_mv_sum = PACK_MAX;
				if (alive_in_round < PRES_MAX)
					alive_in_round++;
				rep.module_alive        = 1'b1;
				rep.module_mv           = MODSUM_W'(cells_mv);
				rep.over_voltage_fault  = cells_flags[FLAG_LOW];
				rep.under_voltage_fault = cells_flags[FLAG_HIGH];
				rep.over_temp_alert     = alert[FLAG_LOW];
				rep.under_temp_alert    = alert[FLAG_HIGH];
			end
			clear_cells();
			return 1'b1;
		end
		KIND_ROUND: begin
			// pack totals; stored flags only count for modules marked present
			pv = pack_mv_sum;
			if (strings > 1)
				pv = pv / strings;
			for (int m = 1; m <= MODULES; m++)
				if (seen_alive[m] && (volt_flags[m] | temp_flags[m]) != '0)
					faulted = 1'b1;
			rep.report_kind   = REPORT_PACK;
			rep.pack_mv       = PACK_W'(pv);
			rep.present_count = PRES_W'(alive_in_round);
			rep.pack_faulted  = faulted;
			pack_mv_sum    = 0;
			alive_in_round = 0;
			return 1'b1;
		end
		default: return 1'b0;
		endcase
	endfunction

	task automatic compare_field(input string fname, input logic [PACK_W-1:0] want,
			input logic [PACK_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			errors++;
		end
	endtask

	// Pop and compare on each accepted result, then predict, then track register writes
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		out_item_t rep;
		if (!arst_n) begin
			reset_monitor();
		end else begin
			if (out_valid && out_ready) begin
				if (due_reports.size() == 0) begin
					$display("%0t ns: result with none expected, actual %p", $time, out_data);
					errors++;
				end else begin
					want = due_reports.pop_front();
					compare_field("report_kind", want.report_kind, out_data.report_kind);
					compare_field("report_module", want.report_module, out_data.report_module);
					compare_field("module_alive", want.module_alive, out_data.module_alive);
					compare_field("module_mv", want.module_mv, out_data.module_mv);
					compare_field("over_voltage_fault", want.over_voltage_fault,
						out_data.over_voltage_fault);
					compare_field("under_voltage_fault", want.under_voltage_fault,
						out_data.under_voltage_fault);
					compare_field("over_temp_alert", want.over_temp_alert,
						out_data.over_temp_alert);
					compare_field("under_temp_alert", want.under_temp_alert,
						out_data.under_temp_alert);
					compare_field("pack_mv", want.pack_mv, out_data.pack_mv);
					compare_field("present_count", want.present_count, out_data.present_count);
					compare_field("pack_faulted", want.pack_faulted, out_data.pack_faulted);
					if (want.report_kind == REPORT_PACK)
						n_pack++;
					else
						n_mod++;
				end
			end
			if (in_valid && in_ready) begin
				if (next_report(in_data, rep))
					due_reports.push_back(rep);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_OVER_VOLTAGE:  ov_limit = cfg_data[MV_W-1:0];
				CFG_UNDER_VOLTAGE: uv_limit = cfg_data[MV_W-1:0];
				CFG_OVER_TEMP:     ot_limit = cfg_data[TEMP_W-1:0];
				CFG_UNDER_TEMP:    ut_limit = cfg_data[TEMP_W-1:0];
				CFG_PARALLEL:      strings  = cfg_data[PAR_W-1:0];
				CFG_TIMEOUT:       fresh_ms = cfg_data[AGE_W-1:0];
				default: ;
				endcase
			end
		end
		fail_count     <= errors;
		reports_due    <= due_reports.size();
		module_reports <= n_mod;
		pack_reports   <= n_pack;
	end

endmodule

FILE: dv/tb_pack_cell_fault_monitor_unit.sv
// Testbench top for pack_cell_fault_monitor_unit: directed and random module rounds over several
// register settings, random stalls on both sides, verdict from the pcfm_checker failure count.
// Depends on pcfm_pkg, pcfm_checker and the block's RTL.
`timescale 1ns / 100ps

module tb_pack_cell_fault_monitor_unit import pcfm_pkg::*;;

	localparam int IDLE_LIMIT   = 4000;
	localparam int SETTLE_CYC   = 30;
	localparam int RANDOM_ITEMS = 1600;
	localparam int LONG_HOLD    = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int reports_due;
	int module_reports;
	int pack_reports;

	// Current settings, used to aim stimulus at the thresholds
	logic [MV_W-1:0]          ov_now;
	logic [MV_W-1:0]          uv_now;
	logic signed [TEMP_W-1:0] ot_now;
	logic signed [TEMP_W-1:0] ut_now;
	logic [AGE_W-1:0]         tmo_now;

	int items_sent;
	int settings_used;
	int rounds_run;
	int tx_burst;

	pack_cell_fault_monitor_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pcfm_checker monitor_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.reports_due    (reports_due),
		.module_reports (module_reports),
		.pack_reports   (pack_reports)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// End the run when no channel moves for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("watchdog: no handshake for %0d cycles at %0t ns", IDLE_LIMIT, $time);
		$display("== FAIL ==");
		$finish;
	end

	// Result side: random hold-off per item, bursts of full speed, now and then a long stall
	initial begin : receiver
		int gap;
		int taken;
		int burst;
		out_ready <= 1'b0;
		taken = 0;
		burst = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (taken % 120 == 60) begin
				gap = LONG_HOLD;
			end else if (burst > 0) begin
				gap = 0;
				burst--;
			end else begin
				gap = $urandom_range(0, 13);
				if ($urandom_range(0, 24) == 0)
					burst = $urandom_range(10, 40);
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready))
				@(posedge clk);
			taken++;
		end
	end

	function automatic in_item_t filler();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(in_item_t)-1:0];
	endfunction

	// Offer one item after a random gap and hold it until taken
	task automatic offer(input in_item_t it);
		int gap;
		if (tx_burst > 0) begin
			gap = 0;
			tx_burst--;
		end else begin
			gap = $urandom_range(0, 13);
			if ($urandom_range(0, 24) == 0)
				tx_burst = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (it.kind != KIND_NONE)
			items_sent++;
	endtask

	task automatic send_cell(input logic [MV_W-1:0] mv);
		in_item_t it;
		it = filler();
		it.kind    = KIND_CELL;
		it.cell_mv = mv;
		offer(it);
	endtask

	task automatic send_close(input logic [ADDR_W-1:0] addr, input logic signed [TEMP_W-1:0] ta,
			input logic signed [TEMP_W-1:0] tb, input logic [AGE_W-1:0] age);
		in_item_t it;
		it = filler();
		it.kind        = KIND_CLOSE;
		it.module_addr = addr;
		it.temp_a      = ta;
		it.temp_b      = tb;
		it.data_age_ms = age;
		offer(it);
	endtask

	task automatic send_round();
		in_item_t it;
		it = filler();
		it.kind = KIND_ROUND;
		offer(it);
	endtask

	function automatic logic [MV_W-1:0] pick_cell();
		case ($urandom_range(0, 9))
		0:       return MV_W'($urandom_range(0, 150));
		1:       return ov_now + MV_W'($urandom_range(0, 2)) - MV_W'(1);
		2:       return uv_now + MV_W'($urandom_range(0, 2)) - MV_W'(1);
		3:       return MV_W'($urandom);
		default: return MV_W'($urandom_range(2800, 4400));
		endcase
	endfunction

	function automatic logic signed [TEMP_W-1:0] pick_temp();
		case ($urandom_range(0, 9))
		0:       return ot_now + TEMP_W'($urandom_range(0, 2)) - TEMP_W'(1);
		1:       return ut_now + TEMP_W'($urandom_range(0, 2)) - TEMP_W'(1);
		2:       return TEMP_W'($urandom);
		default: return TEMP_W'($urandom_range(0, 1650)) - TEMP_W'(400);
		endcase
	endfunction

	// Mostly fresh data; sometimes right at the timeout, saturated or anything
	function automatic logic [AGE_W-1:0] pick_age(input bit fresh);
		int sel;
		sel = fresh ? 9 : $urandom_range(0, 9);
		case (sel)
		0:       return tmo_now;
		1:       return tmo_now - AGE_W'(1);
		2:       return '1;
		3:       return AGE_W'($urandom);
		default: return (tmo_now == '0) ? '0 : AGE_W'($urandom_range(0, tmo_now - 1));
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(0, 1) ? '0 : ADDR_W'($urandom_range(MODULES + 1, 31));
		return ADDR_W'($urandom_range(1, MODULES));
	endfunction

	// One round: modules of cells and a close each, then usually a round end.
	// A long round repeats heavy modules so the pack sum and present count saturate.
	task automatic run_round(input bit long_round);
		int       n_mod;
		int       n_cell;
		in_item_t it;
		n_mod = long_round ? $urandom_range(32, 36) : $urandom_range(1, 6);
		repeat (n_mod) begin
			if (long_round) begin
				n_cell = 9;
			end else begin
				case ($urandom_range(0, 9))
				8:       n_cell = $urandom_range(0, CELLS_PER_MODULE - 1);
				9:       n_cell = $urandom_range(CELLS_PER_MODULE + 1, CELLS_PER_MODULE + 3);
				default: n_cell = CELLS_PER_MODULE;
				endcase
			end
			repeat (n_cell)
				send_cell(long_round ? MV_W'($urandom_range(7300, 8191)) : pick_cell());
			// stray item of any kind, unused kind included
			if ($urandom_range(0, 19) == 0) begin
				it = filler();
				offer(it);
			end
			send_close(long_round ? ADDR_W'($urandom_range(1, MODULES)) : pick_addr(),
				pick_temp(), pick_temp(), pick_age(long_round));
		end
		if ($urandom_range(0, 9) != 0)
			send_round();
		rounds_run++;
	endtask

	task automatic run_rounds(input int upto);
		while (items_sent < upto)
			run_round((rounds_run % 25 == 7) || ($urandom_range(0, 40) == 0));
	endtask

	// Stop offering, wait for every report, then let the block settle
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic cfg_send(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic apply_setting(input logic [MV_W-1:0] ov, input logic [MV_W-1:0] uv,
			input logic signed [TEMP_W-1:0] ot, input logic signed [TEMP_W-1:0] ut,
			input logic [PAR_W-1:0] par, input logic [AGE_W-1:0] tmo, input bit spare);
		cfg_send(CFG_OVER_VOLTAGE, CFG_DATA_W'(ov));
		cfg_send(CFG_UNDER_VOLTAGE, CFG_DATA_W'(uv));
		cfg_send(CFG_OVER_TEMP, CFG_DATA_W'(ot));
		cfg_send(CFG_UNDER_TEMP, CFG_DATA_W'(ut));
		cfg_send(CFG_PARALLEL, CFG_DATA_W'(par));
		cfg_send(CFG_TIMEOUT, CFG_DATA_W'(tmo));
		// unmapped indexes must change nothing
		if (spare) begin
			cfg_send(CFG_SPARE_LO, CFG_DATA_W'($urandom));
			cfg_send(CFG_SPARE_HI, CFG_DATA_W'($urandom));
		end
		cfg_valid <= 1'b0;
		ov_now  = ov;
		uv_now  = uv;
		ot_now  = ot;
		ut_now  = ut;
		tmo_now = tmo;
		settings_used++;
	endtask

	initial begin : stimulus
		in_item_t odd;
		int       share;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_OVER_VOLTAGE;
		cfg_data  <= '0;
		ov_now        = MV_W'(4200);
		uv_now        = MV_W'(3000);
		ot_now        = TEMP_W'(550);
		ut_now        = '0;
		tmo_now       = AGE_W'(3000);
		items_sent    = 0;
		settings_used = 1;
		rounds_run    = 0;
		tx_burst      = 0;
		share         = RANDOM_ITEMS / 6;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pack, then a module hitting the voltage edges with low cells,
		// a saturating sum and a dropped extra cell, extreme temperatures
		send_round();
		send_cell('0);
		send_cell(MV_W'(100));
		send_cell(MV_W'(101));
		send_cell(MV_W'(4200));
		send_cell(MV_W'(4201));
		repeat (7) send_cell('1);
		send_cell(MV_W'(5000));
		send_close(ADDR_W'(1), TEMP_W'(-2048), TEMP_W'(2047), '0);
		// addresses outside the pack, a stale module, an unused kind, a fresh empty module
		send_close('0, '0, '0, '0);
		send_close(ADDR_W'(MODULES + 1), '0, '0, '0);
		send_close('1, '0, '0, '0);
		send_close(ADDR_W'(MODULES), '0, '0, '1);
		odd = filler();
		odd.kind = KIND_NONE;
		offer(odd);
		send_close(ADDR_W'(MODULES), TEMP_W'(550), '0, AGE_W'(2999));
		send_round();

		// Random phases over several settings
		run_rounds(items_sent + share);
		quiesce();
		apply_setting('0, '1, TEMP_W'(-2048), TEMP_W'(2047), '1, '1, 1'b0);
		run_rounds(items_sent + share);
		quiesce();
		apply_setting(MV_W'(5000), '0, TEMP_W'(1250), TEMP_W'(-400), PAR_W'(8), AGE_W'(1), 1'b0);
		run_rounds(items_sent + share);
		quiesce();
		apply_setting(MV_W'($urandom_range(0, 5000)), MV_W'($urandom_range(0, 5000)),
			TEMP_W'($urandom_range(0, 1650)) - TEMP_W'(400),
			TEMP_W'($urandom_range(0, 1650)) - TEMP_W'(400),
			PAR_W'($urandom_range(2, 7)), AGE_W'($urandom_range(1, 65535)), 1'b0);
		run_rounds(items_sent + share);
		quiesce();
		apply_setting(MV_W'(4200), MV_W'(3000), TEMP_W'(550), '0, '0, '0, 1'b1);
		run_rounds(items_sent + share / 3);
		quiesce();
		apply_setting(MV_W'($urandom_range(3500, 4300)), MV_W'($urandom_range(2800, 3500)),
			TEMP_W'($urandom_range(400, 700)), TEMP_W'($urandom_range(0, 200)) - TEMP_W'(100),
			'0, AGE_W'($urandom_range(1000, 65535)), 1'b0);
		run_rounds(RANDOM_ITEMS);
		quiesce();

		$display("Ran %0d items in %0d rounds over %0d register settings,", items_sent,
			rounds_run, settings_used);
		$display("checking %0d module reports and %0d pack reports.", module_reports,
			pack_reports);
		if (fail_count == 0 && reports_due == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
